// File: rtl/rawt_pkg.sv
// shared types and constants for the range assignment window tracker
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package rawt_pkg;

    localparam int DEFAULT_MAX_SLOTS = 16;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int PEER_W   = 32;
    localparam int FIRST_W  = 40;
    localparam int COUNT_W  = 16;
    localparam int TIME_W   = 48;
    localparam int CNT_W    = 5;

    localparam logic [CNT_W-1:0] SLOTS_RESET = CNT_W'(16);

    typedef enum logic [CMD_W-1:0] {
        CMD_OFFER     = 2'd0,
        CMD_DELIVERED = 2'd1,
        CMD_FAILED    = 2'd2,
        CMD_EXPIRE    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_NONE    = 3'd1,
        ST_FULL    = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_PENDING = 3'd4
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic apply;
        logic cfg_write;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/rawt_ctrl.sv
// command sequencer: idle, slot scan, drain of the last read, apply
// depends on rawt_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module rawt_ctrl
    import rawt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       cfg_valid,
    input  wire dp_status_t dp_status,
    output logic            busy,
    output logic            cfg_ready,
    output logic            done,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_APPLY
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (dp_status.scan_last)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE);
    assign done          = done_reg;
    assign cmd.load      = start && (state_reg == S_IDLE);
    assign cmd.scan      = (state_reg == S_SCAN);
    assign cmd.apply     = (state_reg == S_APPLY);
    assign cmd.cfg_write = cfg_valid && (state_reg == S_IDLE);

endmodule

`default_nettype wire

// File: rtl/rawt_dp.sv
// datapath: slot memory, live bits, window and counters, per-slot compare
// and the result registers; depends on rawt_pkg
`timescale 1ns / 1ps
`default_nettype none

module rawt_dp
    import rawt_pkg::*;
#(
    parameter int MAX_SLOTS = DEFAULT_MAX_SLOTS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctrl_cmd_t          cmd,
    output dp_status_t              dp_status,
    input  wire logic [CNT_W-1:0]   cfg_data,
    input  wire logic [CMD_W-1:0]   command,
    input  wire logic [PEER_W-1:0]  peer,
    input  wire logic [FIRST_W-1:0] range_first,
    input  wire logic [COUNT_W-1:0] range_count,
    input  wire logic [TIME_W-1:0]  deadline,
    input  wire logic [TIME_W-1:0]  now_time,
    input  wire logic               store_confirms,
    output logic [STATUS_W-1:0]     status,
    output logic [FIRST_W-1:0]      assigned_first,
    output logic [COUNT_W-1:0]      assigned_count,
    output logic [CNT_W-1:0]        dropped,
    output logic [CNT_W-1:0]        window_now,
    output logic [CNT_W-1:0]        outstanding
);

    localparam int IW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SW  = (IW > CNT_W) ? IW : CNT_W;
    localparam int CLW = CNT_W + 2;

    // slot memory, one read and one write port
    logic [FIRST_W-1:0] slot_first_mem    [MAX_SLOTS];
    logic [COUNT_W-1:0] slot_count_mem    [MAX_SLOTS];
    logic [TIME_W-1:0]  slot_deadline_mem [MAX_SLOTS];
    logic [PEER_W-1:0]  slot_peer_mem     [MAX_SLOTS];

    logic [FIRST_W-1:0] rd_first_reg;
    logic [COUNT_W-1:0] rd_count_reg;
    logic [TIME_W-1:0]  rd_deadline_reg;
    logic [PEER_W-1:0]  rd_peer_reg;

    logic               mem_we;

    // control state
    logic [CNT_W-1:0]     slots_reg, slots_next;
    logic [MAX_SLOTS-1:0] live_reg, live_next;
    logic [CNT_W-1:0]     window_reg, window_next;
    logic [CNT_W-1:0]     live_cnt_reg, live_cnt_next;
    logic [CNT_W-1:0]     run_reg, run_next;
    logic                 eval_valid_reg;

    // per-command working registers
    cmd_t               op_reg;
    logic [PEER_W-1:0]  peer_reg;
    logic [FIRST_W-1:0] first_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [TIME_W-1:0]  deadline_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               confirms_reg;
    logic [IW-1:0]      addr_reg;
    logic [IW-1:0]      eval_idx_reg;
    logic               pend_reg, pend_next;
    logic               free_found_reg, free_found_next;
    logic [IW-1:0]      free_idx_reg, free_idx_next;
    logic               match_found_reg, match_found_next;
    logic [IW-1:0]      match_idx_reg, match_idx_next;
    logic [CNT_W-1:0]   drop_reg, drop_next;

    // result registers
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [FIRST_W-1:0]  a_first_reg, a_first_next;
    logic [COUNT_W-1:0]  a_count_reg, a_count_next;
    logic [CNT_W-1:0]    dropped_reg, dropped_next;

    logic [CNT_W-1:0]   cap;
    logic [CNT_W-1:0]   cap_m1;
    logic               live_hit;
    logic [FIRST_W:0]   slot_end;
    logic [FIRST_W:0]   cand_end;
    logic               overlap;
    logic               exact;
    logic [CNT_W-1:0]   win_half;
    logic [CNT_W-1:0]   run_inc;

    // register value 0 acts as 1, values above the table size clamp
    always_comb
    begin
        if (slots_reg == '0)
        begin
            cap = CNT_W'(1);
        end
        else if (CLW'(slots_reg) > CLW'(MAX_SLOTS))
        begin
            cap = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            cap = slots_reg;
        end
    end

    assign cap_m1              = cap - CNT_W'(1);
    assign dp_status.scan_last = (SW'(addr_reg) == SW'(cap_m1));

    assign live_hit = live_reg[eval_idx_reg];
    assign slot_end = {1'b0, rd_first_reg} + (FIRST_W+1)'(rd_count_reg);
    assign cand_end = {1'b0, first_reg} + (FIRST_W+1)'(count_reg);
    assign overlap  = live_hit && ({1'b0, first_reg} < slot_end)
                      && ({1'b0, rd_first_reg} < cand_end);
    assign exact    = live_hit && (rd_peer_reg == peer_reg)
                      && (rd_first_reg == first_reg) && (rd_count_reg == count_reg);

    assign win_half = (window_reg >> 1) == '0 ? CNT_W'(1) : (window_reg >> 1);
    assign run_inc  = run_reg + CNT_W'(1);

    always_comb
    begin
        slots_next       = slots_reg;
        live_next        = live_reg;
        window_next      = window_reg;
        live_cnt_next    = live_cnt_reg;
        run_next         = run_reg;
        pend_next        = pend_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        drop_next        = drop_reg;
        status_next      = status_reg;
        a_first_next     = a_first_reg;
        a_count_next     = a_count_reg;
        dropped_next     = dropped_reg;
        mem_we           = 1'b0;

        if (cmd.load)
        begin
            pend_next        = 1'b0;
            free_found_next  = 1'b0;
            match_found_next = 1'b0;
            drop_next        = '0;
        end

        // one slot per cycle, in the cycle after its memory read
        if (eval_valid_reg)
        begin
            case (op_reg)
                CMD_OFFER:
                begin
                    if (overlap)
                    begin
                        pend_next = 1'b1;
                    end
                    if (!live_hit && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = eval_idx_reg;
                    end
                end
                CMD_DELIVERED, CMD_FAILED:
                begin
                    if (exact && !match_found_reg)
                    begin
                        match_found_next = 1'b1;
                        match_idx_next   = eval_idx_reg;
                    end
                end
                default:
                begin
                    if (live_hit && (rd_deadline_reg <= now_reg))
                    begin
                        live_next[eval_idx_reg] = 1'b0;
                        drop_next               = drop_reg + CNT_W'(1);
                    end
                end
            endcase
        end

        if (cmd.apply)
        begin
            status_next  = ST_OK;
            a_first_next = '0;
            a_count_next = '0;
            dropped_next = '0;
            case (op_reg)
                CMD_OFFER:
                begin
                    if (live_cnt_reg >= window_reg)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_NONE;
                    end
                    else if (pend_reg)
                    begin
                        status_next = ST_PENDING;
                    end
                    else if (!free_found_reg)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        mem_we                  = 1'b1;
                        live_next[free_idx_reg] = 1'b1;
                        live_cnt_next           = live_cnt_reg + CNT_W'(1);
                        a_first_next            = first_reg;
                        a_count_next            = count_reg;
                    end
                end
                CMD_DELIVERED, CMD_FAILED:
                begin
                    if (!match_found_reg || ((op_reg == CMD_DELIVERED) && !confirms_reg))
                    begin
                        status_next = ST_UNKNOWN;
                    end
                    else
                    begin
                        live_next[match_idx_reg] = 1'b0;
                        if (live_cnt_reg != '0)
                        begin
                            live_cnt_next = live_cnt_reg - CNT_W'(1);
                        end
                        if (op_reg == CMD_DELIVERED)
                        begin
                            // additive increase after a full window of deliveries
                            if (run_inc < window_reg)
                            begin
                                run_next = run_inc;
                            end
                            else
                            begin
                                run_next = '0;
                                if (window_reg < cap)
                                begin
                                    window_next = window_reg + CNT_W'(1);
                                end
                            end
                        end
                        else
                        begin
                            window_next = win_half;
                            run_next    = '0;
                        end
                    end
                end
                default:
                begin
                    dropped_next  = drop_reg;
                    live_cnt_next = live_cnt_reg - drop_reg;
                    if (drop_reg != '0)
                    begin
                        window_next = win_half;
                        run_next    = '0;
                    end
                end
            endcase
        end

        // writing the slot count reopens the table
        if (cmd.cfg_write)
        begin
            slots_next    = cfg_data;
            live_next     = '0;
            window_next   = CNT_W'(1);
            live_cnt_next = '0;
            run_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg      <= SLOTS_RESET;
            live_reg       <= '0;
            window_reg     <= CNT_W'(1);
            live_cnt_reg   <= '0;
            run_reg        <= '0;
            eval_valid_reg <= 1'b0;
        end
        else
        begin
            slots_reg      <= slots_next;
            live_reg       <= live_next;
            window_reg     <= window_next;
            live_cnt_reg   <= live_cnt_next;
            run_reg        <= run_next;
            eval_valid_reg <= cmd.scan;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= cmd_t'(command);
            peer_reg     <= peer;
            first_reg    <= range_first;
            count_reg    <= range_count;
            deadline_reg <= deadline;
            now_reg      <= now_time;
            confirms_reg <= store_confirms;
            addr_reg     <= '0;
        end
        else if (cmd.scan)
        begin
            addr_reg <= addr_reg + IW'(1);
        end
        eval_idx_reg    <= addr_reg;
        pend_reg        <= pend_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        drop_reg        <= drop_next;
        status_reg      <= status_next;
        a_first_reg     <= a_first_next;
        a_count_reg     <= a_count_next;
        dropped_reg     <= dropped_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_first_mem[free_idx_reg]    <= first_reg;
            slot_count_mem[free_idx_reg]    <= count_reg;
            slot_deadline_mem[free_idx_reg] <= deadline_reg;
            slot_peer_mem[free_idx_reg]     <= peer_reg;
        end
        if (cmd.scan)
        begin
            rd_first_reg    <= slot_first_mem[addr_reg];
            rd_count_reg    <= slot_count_mem[addr_reg];
            rd_deadline_reg <= slot_deadline_mem[addr_reg];
            rd_peer_reg     <= slot_peer_mem[addr_reg];
        end
    end

    assign status         = status_reg;
    assign assigned_first = a_first_reg;
    assign assigned_count = a_count_reg;
    assign dropped        = dropped_reg;
    assign window_now     = window_reg;
    assign outstanding    = live_cnt_reg;

endmodule

`default_nettype wire

// File: rtl/range_assignment_window_tracker_unit.sv
// top level of the range assignment window tracker
// depends on rawt_pkg, rawt_ctrl and rawt_dp
`timescale 1ns / 1ps
`default_nettype none

// Usage
// - command channel: a command is taken at a rising edge with start high and
//   busy low; command, peer, range and time fields are sampled at that edge
// - result: done is high for exactly one cycle with status, assigned range,
//   dropped count, window_now and outstanding valid in that cycle; there is
//   no backpressure, the receiver must take it then
// - each command walks the slot table one slot per cycle through the single
//   read port of the slot memory: busy stays high through the scan of cap
//   slots, cap being the clamped slot count, the drain of the last read and
//   the apply step; done is high in the first cycle with busy low, and a new
//   command may start in that same cycle, so a command is not taken before
//   the last one is through
// - configuration: cfg_data is written when cfg_valid and cfg_ready are both
//   high; cfg_ready is high while no command is in progress; a write clears
//   the table, sets the window to one and the counters to zero
// - reset: slot count 16, empty table, window one; no clearing pass is
//   needed since slot live bits are flip-flops
module range_assignment_window_tracker_unit
    import rawt_pkg::*;
#(
    parameter int MAX_SLOTS = DEFAULT_MAX_SLOTS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [CMD_W-1:0]    command,
    input  wire logic [PEER_W-1:0]   peer,
    input  wire logic [FIRST_W-1:0]  range_first,
    input  wire logic [COUNT_W-1:0]  range_count,
    input  wire logic [TIME_W-1:0]   deadline,
    input  wire logic [TIME_W-1:0]   now_time,
    input  wire logic                store_confirms,
    output logic                     done,
    output logic [STATUS_W-1:0]      status,
    output logic [FIRST_W-1:0]       assigned_first,
    output logic [COUNT_W-1:0]       assigned_count,
    output logic [CNT_W-1:0]         dropped,
    output logic [CNT_W-1:0]         window_now,
    output logic [CNT_W-1:0]         outstanding,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CNT_W-1:0]    cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    rawt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .dp_status (dp_status),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .done      (done),
        .cmd       (cmd)
    );

    rawt_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .dp_status      (dp_status),
        .cfg_data       (cfg_data),
        .command        (command),
        .peer           (peer),
        .range_first    (range_first),
        .range_count    (range_count),
        .deadline       (deadline),
        .now_time       (now_time),
        .store_confirms (store_confirms),
        .status         (status),
        .assigned_first (assigned_first),
        .assigned_count (assigned_count),
        .dropped        (dropped),
        .window_now     (window_now),
        .outstanding    (outstanding)
    );

endmodule

`default_nettype wire

// File: rtl/rawt_checker.sv
// port-level checks for the range assignment window tracker, bound to the top
// depends on rawt_pkg and range_assignment_window_tracker_unit
`timescale 1ns / 1ps
`default_nettype none

module rawt_checker
    import rawt_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [COUNT_W-1:0]  assigned_count,
    input wire logic [CNT_W-1:0]    window_now
);

    // an accepted command keeps the block busy in the next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    // the result strobe only follows the end of a command
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe outside the end of a command");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // window never drops below one
    a_window_floor: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> window_now != '0)
        else $error("window reported as zero");

    // only a successful transfer of an offer reports a range
    a_assigned_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && (assigned_count != '0) |-> (status == ST_OK))
        else $error("range reported with a failing status");

endmodule

bind range_assignment_window_tracker_unit rawt_checker u_rawt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .assigned_count (assigned_count),
    .window_now     (window_now)
);

`default_nettype wire
